### design/pte_pkg.sv
package pte_pkg;

  // fixed widths of the value fields (Q1.31 by default)
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CFG_W  = 4;
  localparam int ROW_W  = 3;
  localparam int OP_W   = 2;

  // parameter defaults
  localparam int MAX_STATES_DEF = 8;
  localparam int TIME_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF  = 31;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_INIT  = 2'd0,
    OP_LOAD_TRANS = 2'd1,
    OP_LOAD_EXIT  = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;      // query start: w <= alpha, idx <= own index, acc <= 0
    logic issue;     // one MAC issue, ring rotates one place
    logic use_exit;  // final pass: multiply by exit entry instead of T
    logic latch;     // end of a step: w <= acc, acc <= 0
  } ctl_t;

endpackage

### design/pte_cell.sv
module pte_cell #(
  parameter int MAX_STATES = pte_pkg::MAX_STATES_DEF,
  parameter int FRAC_BITS  = pte_pkg::FRAC_BITS_DEF,
  parameter int CELL_IDX   = 0,
  localparam int IDX_W     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pte_pkg::ctl_t              ctl,
  input  logic                       active,
  input  logic                       wr_alpha,
  input  logic                       wr_exit,
  input  logic                       wr_col,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [pte_pkg::DATA_W-1:0] wr_data,
  input  logic [pte_pkg::DATA_W-1:0] w_in,
  input  logic [pte_pkg::DATA_W-1:0] t_in,
  input  logic [IDX_W-1:0]           idx_in,
  output logic [pte_pkg::DATA_W-1:0] w_out,
  output logic [pte_pkg::DATA_W-1:0] t_out,
  output logic [IDX_W-1:0]           idx_out,
  output logic [pte_pkg::DATA_W-1:0] acc_out
);
  import pte_pkg::*;

  // column CELL_IDX of T, indexed by source state
  logic [DATA_W-1:0] col_mem [MAX_STATES];
  logic [DATA_W-1:0] alpha;
  logic [DATA_W-1:0] texit;
  logic [DATA_W-1:0] w;
  logic [DATA_W-1:0] acc;
  logic [IDX_W-1:0]  idx;
  logic [PROD_W-1:0] prod;
  logic              prod_vld;

  logic [DATA_W-1:0] operand;
  logic [PROD_W-1:0] prod_sh;
  logic [DATA_W-1:0] prod_sat;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sum_sat;
  logic              rot;

  assign rot     = ctl.issue & active;
  assign operand = ctl.use_exit ? texit : col_mem[idx];

  // truncate by FRAC_BITS, saturate to the field width
  assign prod_sh  = prod >> FRAC_BITS;
  assign prod_sat = (prod_sh[PROD_W-1:DATA_W] != '0) ? '1 : prod_sh[DATA_W-1:0];
  assign sum      = {1'b0, acc} + {1'b0, prod_sat};
  assign sum_sat  = sum[DATA_W] ? '1 : sum[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        col_mem[i] <= '0;
      end
      alpha    <= '0;
      texit    <= '0;
      prod_vld <= 1'b0;
    end else begin
      if (wr_col) begin
        col_mem[wr_addr] <= wr_data;
      end
      if (wr_alpha) begin
        alpha <= wr_data;
      end
      // exit entry rides the ring with w and comes home after m places
      if (wr_exit) begin
        texit <= wr_data;
      end else if (rot) begin
        texit <= t_in;
      end
      prod_vld <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      w   <= alpha;
      idx <= IDX_W'(CELL_IDX);
    end else if (rot) begin
      w   <= w_in;
      idx <= idx_in;
    end else if (ctl.latch) begin
      w <= acc;
    end
    prod <= PROD_W'(w) * PROD_W'(operand);
    if (ctl.load || ctl.latch) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= sum_sat;
    end
  end

  assign w_out   = w;
  assign t_out   = texit;
  assign idx_out = idx;
  assign acc_out = acc;

endmodule

### design/pte_ctrl.sv
module pte_ctrl #(
  parameter int MAX_STATES = pte_pkg::MAX_STATES_DEF,
  parameter int TIME_BITS  = pte_pkg::TIME_BITS_DEF,
  localparam int CNT_W     = $clog2(MAX_STATES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 query,
  input  logic [TIME_BITS-1:0] k,
  input  logic [CNT_W-1:0]     m_in,
  output logic                 busy,
  output logic                 emit,
  output logic [CNT_W-1:0]     m,
  output pte_pkg::ctl_t        ctl
);
  import pte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_LATCH,
    S_FINISH
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] steps_left;
  logic                 final_ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      steps_left <= '0;
      final_ph   <= 1'b0;
      m          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (query) begin
            m          <= m_in;
            steps_left <= k;
            final_ph   <= (k == '0);
            cnt        <= '0;
            state      <= (m_in == '0) ? S_FINISH : S_ISSUE;
          end
        end
        S_ISSUE: begin
          cnt <= cnt + 1'b1;
          if (cnt == m - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= final_ph ? S_FINISH : S_LATCH;
        end
        S_LATCH: begin
          steps_left <= steps_left - 1'b1;
          final_ph   <= (steps_left == TIME_BITS'(1));
          cnt        <= '0;
          state      <= S_ISSUE;
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign emit         = (state == S_FINISH);
  assign ctl.load     = query & (state == S_IDLE);
  assign ctl.issue    = (state == S_ISSUE);
  assign ctl.use_exit = final_ph;
  assign ctl.latch    = (state == S_LATCH);

endmodule

### design/phase_type_pmf_engine_core.sv
// Discrete phase-type probability mass engine: pmf = alpha * T^k * t.
// Request channel: start/busy. A request is taken at a rising edge with start
// high and busy low. op selects load of an alpha entry (row), a T entry
// (row = source, col = destination), an exit entry (row), or a query of
// time_req steps. Loads give no result and leave busy low.
// Result channel: done is high for exactly one cycle with pmf valid; the
// receiver cannot stall it, so it must take the value in that cycle.
// Config: cfg_wr_en/cfg_wr_data write state_count (m) at any edge; write it
// only while idle.
// A query runs each of the k steps as m issues through the one multiplier in each
// cell, one drain and one latch; the exit dot product takes m issues and a drain.
// When m is zero the query goes straight to the finish state. busy is high from the
// request edge until the done cycle, when a new request may already be taken.
// Reset (rst, synchronous) clears alpha, T, t, state_count and the sequencer.
module phase_type_pmf_engine_core #(
  parameter int MAX_STATES = pte_pkg::MAX_STATES_DEF,
  parameter int TIME_BITS  = pte_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS  = pte_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [pte_pkg::OP_W-1:0]   op,
  input  logic [pte_pkg::ROW_W-1:0]  row,
  input  logic [pte_pkg::ROW_W-1:0]  col,
  input  logic [pte_pkg::DATA_W-1:0] value,
  input  logic [TIME_BITS-1:0]       time_req,
  output logic                       done,
  output logic [pte_pkg::DATA_W-1:0] pmf,
  input  logic                       cfg_wr_en,
  input  logic [pte_pkg::CFG_W-1:0]  cfg_wr_data
);
  import pte_pkg::*;

  localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CNT_W = $clog2(MAX_STATES + 1);

  logic [CFG_W-1:0]  state_count;
  logic [CNT_W-1:0]  m_req;
  logic [CNT_W-1:0]  m;
  logic              take;
  logic              query;
  logic              emit;
  logic              row_ok;
  logic              col_ok;
  logic [IDX_W-1:0]  row_idx;
  ctl_t              ctl;

  // ring taps: each cell hands w, t and source index to its downstream neighbour
  logic [DATA_W-1:0] w_o   [MAX_STATES];
  logic [DATA_W-1:0] t_o   [MAX_STATES];
  logic [IDX_W-1:0]  idx_o [MAX_STATES];
  logic [DATA_W-1:0] acc_o [MAX_STATES];

  assign take    = start & ~busy;
  assign query   = take & (op == OP_QUERY);
  assign row_ok  = (32'(row) < 32'(MAX_STATES));
  assign col_ok  = (32'(col) < 32'(MAX_STATES));
  assign row_idx = IDX_W'(32'(row));

  // counts above MAX_STATES act as MAX_STATES
  assign m_req = (32'(state_count) > 32'(MAX_STATES)) ? CNT_W'(MAX_STATES)
                                                       : CNT_W'(state_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= '0;
      done        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        state_count <= cfg_wr_data;
      end
      done <= emit;
    end
  end

  // cell 0 holds the finished dot product in the finish cycle
  always_ff @(posedge clk) begin
    if (emit) begin
      pmf <= acc_o[0];
    end
  end

  pte_ctrl #(
    .MAX_STATES (MAX_STATES),
    .TIME_BITS  (TIME_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .query (query),
    .k     (time_req),
    .m_in  (m_req),
    .busy  (busy),
    .emit  (emit),
    .m     (m),
    .ctl   (ctl)
  );

  for (genvar j = 0; j < MAX_STATES; j++) begin : g_cell
    localparam int NXT = (j + 1) % MAX_STATES;
    logic up_wrap;
    logic active;

    // last active cell closes the ring back to cell 0
    assign up_wrap = (CNT_W'(j) == m - 1'b1);
    assign active  = (CNT_W'(j) < m);

    pte_cell #(
      .MAX_STATES (MAX_STATES),
      .FRAC_BITS  (FRAC_BITS),
      .CELL_IDX   (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .active   (active),
      .wr_alpha (take && (op == OP_LOAD_INIT) && row_ok && (32'(row) == j)),
      .wr_exit  (take && (op == OP_LOAD_EXIT) && row_ok && (32'(row) == j)),
      .wr_col   (take && (op == OP_LOAD_TRANS) && row_ok && col_ok && (32'(col) == j)),
      .wr_addr  (row_idx),
      .wr_data  (value),
      .w_in     (up_wrap ? w_o[0]   : w_o[NXT]),
      .t_in     (up_wrap ? t_o[0]   : t_o[NXT]),
      .idx_in   (up_wrap ? idx_o[0] : idx_o[NXT]),
      .w_out    (w_o[j]),
      .t_out    (t_o[j]),
      .idx_out  (idx_o[j]),
      .acc_out  (acc_o[j])
    );
  end

endmodule
